// ===== design/rmjs_pkg.sv =====
// Package for the rate-monotonic job scheduler core.
// Holds the table size, payload structs, table record, state and command codes.
// No dependencies.
package rmjs_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [6:0] REMOVED_MAX = 7'd127;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ACT_LOADED  = 3'd0,
    ACT_IDLE    = 3'd1,
    ACT_RAN     = 3'd2,
    ACT_DL_RM   = 3'd3,
    ACT_MISS_RM = 3'd4,
    ACT_READ    = 3'd5,
    ACT_DONE    = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_FRESH     = 2'd0,
    ST_PREEMPTED = 2'd1,
    ST_RUNNING   = 2'd2,
    ST_REMOVED   = 2'd3
  } job_status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] job_id;
    logic [15:0] exec_time;
    logic [15:0] job_period;
    logic [31:0] release_time;
    logic [5:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  entry;
    logic [15:0] entry_job_id;
    logic [31:0] time_now;
    logic [15:0] remaining;
    logic [31:0] entry_wait;
    logic [6:0]  missed_count;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] period;
    logic [31:0] release_t;
    logic [15:0] left;
    job_status_e status;
    logic [31:0] wait_cnt;
  } rec_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_LOAD,
    CMD_FULL,
    CMD_RD_ISSUE,
    CMD_RD_RESULT,
    CMD_SCAN_CLR,
    CMD_SCAN,
    CMD_DONE_RESULT,
    CMD_PRE_RD,
    CMD_PRE_WR,
    CMD_IDLE_RESULT,
    CMD_DL_RD,
    CMD_DL_WR,
    CMD_WIN_RD,
    CMD_WIN_WR,
    CMD_SWEEP,
    CMD_SWEEP_DRAIN,
    CMD_PUSH
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_RESULT,
    S_SCAN,
    S_SCAN_DRAIN,
    S_DECIDE,
    S_PRE_RD,
    S_PRE_WR,
    S_BRANCH,
    S_DL_RD,
    S_DL_WR,
    S_WIN_RD,
    S_WIN_WR,
    S_SWEEP,
    S_SWEEP_DRAIN,
    S_OUT
  } state_e;

  typedef struct packed {
    opcode_e op;
    logic    table_full;
    logic    table_empty;
    logic    cnt_last;
    logic    any_live;
    logic    found;
    logic    dl_found;
    logic    pre_needed;
    logic    miss;
    logic    out_free;
  } dp_status_t;

endpackage

// ===== design/rate_monotonic_job_scheduler_core.sv =====
// Top level of the rate-monotonic job scheduler core.
// Instantiates rmjs_ctrl and rmjs_datapath; uses rmjs_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------
//  in      | input     | in_valid_i / in_ready_o | in_i  (in_t)
//  out     | output    | out_valid_o/ out_ready_i| out_o (out_t)
//
// Loads and reads each end with a result in the output register; unknown items give no result.
// A step scans the table at one entry per cycle through the single read port of the
// job memory, then ends idle, all done or in a removal, or runs the job and sweeps the
// wait count of every other ready entry; a preemption adds a write of the previous job.
// Reset is asynchronous; the memory needs no clearing since entries are written on load.
// A held result stalls only the next item's finish, not its acceptance.
module rate_monotonic_job_scheduler_core import rmjs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  cmd_e       cmd;
  dp_status_t status;

  rmjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmjs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// ===== design/rmjs_ctrl.sv =====
// Controller state machine for the scheduler core.
// Sequences loads, reads and scheduler steps by commands to rmjs_datapath; uses rmjs_pkg.
module rmjs_ctrl import rmjs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.op)
          OP_LOAD: begin
            cmd_o   = status_i.table_full ? CMD_FULL : CMD_LOAD;
            state_d = S_OUT;
          end
          OP_READ: begin
            cmd_o   = CMD_RD_ISSUE;
            state_d = S_RD_RESULT;
          end
          OP_STEP: begin
            if (status_i.table_empty) begin
              cmd_o   = CMD_DONE_RESULT;
              state_d = S_OUT;
            end else begin
              cmd_o   = CMD_SCAN_CLR;
              state_d = S_SCAN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RD_RESULT: begin
        cmd_o   = CMD_RD_RESULT;
        state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (status_i.cnt_last) begin
          state_d = S_SCAN_DRAIN;
        end
      end
      S_SCAN_DRAIN: state_d = S_DECIDE;
      S_DECIDE: begin
        if (!status_i.any_live) begin
          cmd_o   = CMD_DONE_RESULT;
          state_d = S_OUT;
        end else if (status_i.pre_needed) begin
          state_d = S_PRE_RD;
        end else begin
          state_d = S_BRANCH;
        end
      end
      S_PRE_RD: begin
        cmd_o   = CMD_PRE_RD;
        state_d = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd_o   = CMD_PRE_WR;
        state_d = S_BRANCH;
      end
      S_BRANCH: begin
        if (!status_i.found) begin
          cmd_o   = CMD_IDLE_RESULT;
          state_d = S_OUT;
        end else if (status_i.dl_found) begin
          state_d = S_DL_RD;
        end else begin
          state_d = S_WIN_RD;
        end
      end
      S_DL_RD: begin
        cmd_o   = CMD_DL_RD;
        state_d = S_DL_WR;
      end
      S_DL_WR: begin
        cmd_o   = CMD_DL_WR;
        state_d = S_OUT;
      end
      S_WIN_RD: begin
        cmd_o   = CMD_WIN_RD;
        state_d = S_WIN_WR;
      end
      S_WIN_WR: begin
        cmd_o   = CMD_WIN_WR;
        state_d = status_i.miss ? S_OUT : S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o = CMD_SWEEP;
        if (status_i.cnt_last) begin
          state_d = S_SWEEP_DRAIN;
        end
      end
      S_SWEEP_DRAIN: begin
        cmd_o   = CMD_SWEEP_DRAIN;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_PUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/rmjs_datapath.sv =====
// Datapath for the scheduler core: job table memory, scan pipeline, counters, result regs.
// Driven by commands from rmjs_ctrl; uses rmjs_pkg.
module rmjs_datapath import rmjs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  in_t        in_i,
  output dp_status_t status_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_t       out_o
);

  rec_t mem_q [TABLE_ENTRIES];
  rec_t rd_q;
  in_t  in_q;
  out_t res_q, res_d, out_q;
  logic res_load;

  logic [AW-1:0] raddr, waddr;
  logic          we;
  rec_t          wdata;

  logic [LW-1:0] cnt_q, cnt_d, loaded_q;
  logic [31:0]   tick_q, tick_d;
  logic [6:0]    removed_q, removed_d, removed_inc;
  logic          last_valid_q, last_valid_d;
  logic [AW-1:0] last_q, last_d;
  logic          pipe_valid_q, pipe_sweep_q;
  logic [AW-1:0] pipe_idx_q;
  logic          out_valid_q;

  logic          any_live_q, found_q, dl_found_q, last_live_q;
  logic [AW-1:0] win_idx_q, dl_idx_q;
  logic [15:0]   win_per_q, win_id_q, dl_id_q;

  logic          live, ready, dl_hit, miss, rd_hit;
  logic [32:0]   deadline;
  logic [AW-1:0] loaded_idx;

  assign live        = (rd_q.left != 16'd0) && (rd_q.status != ST_REMOVED);
  assign ready       = live && (rd_q.release_t <= tick_q);
  assign deadline    = {1'b0, rd_q.release_t} + {17'd0, rd_q.period};
  assign dl_hit      = live && (deadline == {1'b0, tick_q});
  assign miss        = (({1'b0, tick_q} + {17'd0, rd_q.left}) > deadline) &&
                       (rd_q.status != ST_RUNNING);
  assign removed_inc = (removed_q == REMOVED_MAX) ? removed_q : removed_q + 7'd1;
  assign rd_hit      = 32'(in_q.read_index) < 32'(loaded_q);
  assign loaded_idx  = loaded_q[AW-1:0];

  always_comb begin
    status_o.op          = opcode_e'(in_q.opcode);
    status_o.table_full  = loaded_q == LW'(TABLE_ENTRIES);
    status_o.table_empty = loaded_q == '0;
    status_o.cnt_last    = cnt_q == loaded_q - LW'(1);
    status_o.any_live    = any_live_q;
    status_o.found       = found_q;
    status_o.dl_found    = dl_found_q;
    status_o.pre_needed  = last_valid_q && last_live_q && (!found_q || last_q != win_idx_q);
    status_o.miss        = miss;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    raddr        = cnt_q[AW-1:0];
    waddr        = pipe_idx_q;
    we           = 1'b0;
    wdata        = rd_q;
    res_load     = 1'b0;
    res_d        = '0;
    res_d.time_now     = tick_q;
    res_d.missed_count = removed_q;
    cnt_d        = cnt_q;
    tick_d       = tick_q;
    removed_d    = removed_q;
    last_valid_d = last_valid_q;
    last_d       = last_q;

    // sweep write-back: bump wait of every other ready entry
    if (pipe_valid_q && pipe_sweep_q && pipe_idx_q != win_idx_q && ready &&
        rd_q.wait_cnt != '1) begin
      we             = 1'b1;
      wdata.wait_cnt = rd_q.wait_cnt + 32'd1;
    end

    case (cmd_i)
      CMD_LOAD: begin
        we              = 1'b1;
        waddr           = loaded_idx;
        wdata.id        = in_q.job_id;
        wdata.period    = in_q.job_period;
        wdata.release_t = in_q.release_time;
        wdata.left      = in_q.exec_time;
        wdata.status    = ST_FRESH;
        wdata.wait_cnt  = '0;
        res_load           = 1'b1;
        res_d.action       = ACT_LOADED;
        res_d.entry        = 6'(loaded_idx);
        res_d.entry_job_id = in_q.job_id;
        res_d.remaining    = in_q.exec_time;
      end
      CMD_FULL: begin
        res_load         = 1'b1;
        res_d.action     = ACT_LOADED;
        res_d.table_full = 1'b1;
      end
      CMD_RD_ISSUE: raddr = AW'(in_q.read_index);
      CMD_RD_RESULT: begin
        res_load     = 1'b1;
        res_d.action = ACT_READ;
        res_d.entry  = in_q.read_index;
        if (rd_hit) begin
          res_d.entry_job_id = rd_q.id;
          res_d.remaining    = rd_q.left;
          res_d.entry_wait   = rd_q.wait_cnt;
        end
      end
      CMD_SCAN_CLR: cnt_d = '0;
      CMD_SCAN, CMD_SWEEP: cnt_d = cnt_q + LW'(1);
      CMD_DONE_RESULT: begin
        res_load     = 1'b1;
        res_d.action = ACT_DONE;
      end
      CMD_PRE_RD: raddr = last_q;
      CMD_PRE_WR: begin
        we           = 1'b1;
        waddr        = last_q;
        wdata.status = ST_PREEMPTED;
      end
      CMD_IDLE_RESULT: begin
        tick_d         = tick_q + 32'd1;
        last_valid_d   = 1'b0;
        res_load       = 1'b1;
        res_d.action   = ACT_IDLE;
        res_d.time_now = tick_q + 32'd1;
      end
      CMD_DL_RD, CMD_WIN_RD: begin
        raddr        = (cmd_i == CMD_DL_RD) ? dl_idx_q : win_idx_q;
        last_valid_d = 1'b1;
        last_d       = win_idx_q;
      end
      CMD_DL_WR: begin
        we                 = 1'b1;
        waddr              = dl_idx_q;
        wdata.status       = ST_REMOVED;
        removed_d          = removed_inc;
        res_load           = 1'b1;
        res_d.action       = ACT_DL_RM;
        res_d.entry        = 6'(dl_idx_q);
        res_d.entry_job_id = rd_q.id;
        res_d.remaining    = rd_q.left;
        res_d.entry_wait   = rd_q.wait_cnt;
        res_d.missed_count = removed_inc;
      end
      CMD_WIN_WR: begin
        we                 = 1'b1;
        waddr              = win_idx_q;
        cnt_d              = '0;
        res_load           = 1'b1;
        res_d.entry        = 6'(win_idx_q);
        res_d.entry_job_id = rd_q.id;
        res_d.entry_wait   = rd_q.wait_cnt;
        if (miss) begin
          wdata.status       = ST_REMOVED;
          removed_d          = removed_inc;
          res_d.action       = ACT_MISS_RM;
          res_d.remaining    = rd_q.left;
          res_d.missed_count = removed_inc;
        end else begin
          wdata.status    = ST_RUNNING;
          wdata.left      = rd_q.left - 16'd1;
          res_d.action    = ACT_RAN;
          res_d.remaining = rd_q.left - 16'd1;
          res_d.time_now  = tick_q + 32'd1;
        end
      end
      CMD_SWEEP_DRAIN: tick_d = tick_q + 32'd1;
      default: ;
    endcase
  end

  // table memory and payload registers
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
    if (cmd_i == CMD_ACCEPT) begin
      in_q <= in_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (cmd_i == CMD_PUSH) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      loaded_q     <= '0;
      tick_q       <= '0;
      removed_q    <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      pipe_valid_q <= 1'b0;
      pipe_sweep_q <= 1'b0;
      pipe_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      tick_q       <= tick_d;
      removed_q    <= removed_d;
      last_valid_q <= last_valid_d;
      last_q       <= last_d;
      pipe_valid_q <= (cmd_i == CMD_SCAN) || (cmd_i == CMD_SWEEP);
      pipe_sweep_q <= cmd_i == CMD_SWEEP;
      pipe_idx_q   <= cnt_q[AW-1:0];
      if (cmd_i == CMD_LOAD) begin
        loaded_q <= loaded_q + LW'(1);
      end
      if (cmd_i == CMD_PUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan accumulators: liveness, winner, deadline hit, previous choice
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_live_q  <= 1'b0;
      found_q     <= 1'b0;
      dl_found_q  <= 1'b0;
      last_live_q <= 1'b0;
      win_idx_q   <= '0;
      win_per_q   <= '0;
      win_id_q    <= '0;
      dl_idx_q    <= '0;
      dl_id_q     <= '0;
    end else if (cmd_i == CMD_SCAN_CLR) begin
      any_live_q  <= 1'b0;
      found_q     <= 1'b0;
      dl_found_q  <= 1'b0;
      last_live_q <= 1'b0;
    end else if (pipe_valid_q && !pipe_sweep_q) begin
      if (live) begin
        any_live_q <= 1'b1;
      end
      if (ready && (!found_q || rd_q.period < win_per_q ||
                    (rd_q.period == win_per_q && rd_q.id < win_id_q))) begin
        found_q   <= 1'b1;
        win_idx_q <= pipe_idx_q;
        win_per_q <= rd_q.period;
        win_id_q  <= rd_q.id;
      end
      if (dl_hit && (!dl_found_q || rd_q.id < dl_id_q)) begin
        dl_found_q <= 1'b1;
        dl_idx_q   <= pipe_idx_q;
        dl_id_q    <= rd_q.id;
      end
      if (last_valid_q && pipe_idx_q == last_q && live) begin
        last_live_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef NO_ASSERTIONS
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= LW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q == $past(tick_q)) || (tick_q == $past(tick_q) + 32'd1))
    else $error("tick moved by more than one");
  a_removed_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    removed_q >= $past(removed_q))
    else $error("removal count decreased");
  a_sweep_skip_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && pipe_sweep_q && pipe_valid_q) |-> (waddr != win_idx_q))
    else $error("wait sweep wrote the running entry");
`endif

endmodule
